@@ rtl/mpool_pkg.sv @@
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared types and constants of the 2-d max pooling window block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpool_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int CFG_W    = 7;
  // signed window position: covers 63*7 plus a window and the largest plane
  localparam int POS_W    = 12;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_STEP_SIZE    = 2'd1,
    CFG_PLANE_HEIGHT = 2'd2,
    CFG_PLANE_WIDTH  = 2'd3
  } cfg_idx_t;

  localparam logic [2:0] WINDOW_SIZE_RST  = 3'd5;
  localparam logic [2:0] STEP_SIZE_RST    = 3'd1;
  localparam logic [6:0] PLANE_HEIGHT_RST = 7'd64;
  localparam logic [6:0] PLANE_WIDTH_RST  = 7'd64;

endpackage

@@ rtl/mpool_if.sv @@
// ----------------------------------------------------------------------------
// mpool_if
// Valid/ready channels of the max pooling block: request in, result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpool_in_if;
  logic                                   valid;
  logic                                   ready;
  mpool_pkg::req_t                        req_type;
  logic [mpool_pkg::ROW_W-1:0]            row;
  logic [mpool_pkg::COL_W-1:0]            col;
  logic signed [mpool_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, req_type, row, col, sample, input ready);
  modport sink   (input valid, req_type, row, col, sample, output ready);
endinterface

interface mpool_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mpool_pkg::SAMPLE_W-1:0]  max_value;
  logic                                   window_empty;

  modport source (output valid, max_value, window_empty, input ready);
  modport sink   (input valid, max_value, window_empty, output ready);
endinterface

@@ rtl/max_pool_2d_window_top.sv @@
// ----------------------------------------------------------------------------
// max_pool_2d_window_top
// Max pooling over one plane held in RAM: writes store samples, queries
// return the largest in-plane sample of a square window.
// A write is stored as it is taken. A query with effective window k (window size,
// capped at MAX_WINDOW) walks its k*k positions, one a cycle, reading the RAM for
// in-plane ones, then ST_LAST and ST_FINISH; size zero goes straight to ST_FINISH.
// The next item is taken once the result sits in the output register, which
// holds it until taken. No item is taken while reset is asserted.
// Reset clears control and configuration; the plane RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_pool_2d_window_top #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_WINDOW = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mpool_in_if.sink                  in_chan,
  mpool_out_if.source               out_chan,
  input  logic                      cfg_we,
  input  mpool_pkg::cfg_idx_t       cfg_index,
  input  logic [mpool_pkg::CFG_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int PW    = mpool_pkg::POS_W;
  localparam int SW    = mpool_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LAST,
    ST_FINISH
  } state_t;

  // configuration
  logic [2:0] win_size_r;
  logic [2:0] step_r;
  logic [6:0] height_r;
  logic [6:0] width_r;

  // control and datapath
  state_t               state_r, state_nxt;
  logic [WIN_W-1:0]     i_r, i_nxt;
  logic [WIN_W-1:0]     j_r, j_nxt;
  logic [WIN_W-1:0]     k_r, k_nxt;
  logic signed [PW-1:0] r0_r, r0_nxt;
  logic signed [PW-1:0] c0_r, c0_nxt;
  logic                 pend_r, pend_nxt;
  logic signed [SW-1:0] best_r, best_nxt;
  logic                 found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_max_r, out_max_nxt;
  logic                 out_empty_r, out_empty_nxt;

  logic                 in_acc;
  logic                 is_query;
  logic [8:0]           row_prod, col_prod;
  logic [1:0]           pad;
  logic signed [PW-1:0] h_eff, w_eff;
  logic signed [PW-1:0] ir, ic;
  logic                 pos_ok;
  logic                 last_j, last_i;
  logic                 out_free;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [SW-1:0]        rd_data;

  assign in_chan.ready = rst_n && (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_query      = (in_chan.req_type == mpool_pkg::REQ_QUERY);

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= mpool_pkg::WINDOW_SIZE_RST;
      step_r     <= mpool_pkg::STEP_SIZE_RST;
      height_r   <= mpool_pkg::PLANE_HEIGHT_RST;
      width_r    <= mpool_pkg::PLANE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpool_pkg::CFG_WINDOW_SIZE:  win_size_r <= cfg_data[2:0];
        mpool_pkg::CFG_STEP_SIZE:    step_r     <= cfg_data[2:0];
        mpool_pkg::CFG_PLANE_HEIGHT: height_r   <= cfg_data;
        mpool_pkg::CFG_PLANE_WIDTH:  width_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- plane store ----------------
  assign wr_en   = in_acc && !is_query
                   && (32'(in_chan.row) < MAX_ROWS) && (32'(in_chan.col) < MAX_COLS);
  assign wr_addr = AW'(in_chan.row) * AW'(MAX_COLS) + AW'(in_chan.col);

  mpool_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_plane_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_chan.sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------- window walk ----------------
  assign row_prod = 9'(in_chan.row) * 9'(step_r);
  assign col_prod = 9'(in_chan.col) * 9'(step_r);
  assign pad      = win_size_r[2:1];

  assign h_eff = (32'(height_r) > MAX_ROWS) ? PW'(MAX_ROWS) : PW'(height_r);
  assign w_eff = (32'(width_r) > MAX_COLS) ? PW'(MAX_COLS) : PW'(width_r);

  assign ir = r0_r + $signed(PW'(i_r));
  assign ic = c0_r + $signed(PW'(j_r));

  assign pos_ok = !ir[PW-1] && (ir < h_eff) && !ic[PW-1] && (ic < w_eff);

  assign rd_en   = (state_r == ST_RUN) && pos_ok;
  assign rd_addr = AW'($unsigned(ir)) * AW'(MAX_COLS) + AW'($unsigned(ic));

  assign last_j   = (WIN_W'(j_r + 1'b1) == k_r);
  assign last_i   = (WIN_W'(i_r + 1'b1) == k_r);
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    r0_nxt        = r0_r;
    c0_nxt        = c0_r;
    pend_nxt      = rd_en;
    best_nxt      = best_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_max_nxt   = out_max_r;
    out_empty_nxt = out_empty_r;

    // fold in the sample read last cycle
    if (pend_r) begin
      if (!found_r || ($signed(rd_data) > best_r)) begin
        best_nxt = $signed(rd_data);
      end
      found_nxt = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          k_nxt     = (32'(win_size_r) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW)
                                                     : WIN_W'(win_size_r);
          i_nxt     = '0;
          j_nxt     = '0;
          r0_nxt    = $signed(PW'(row_prod)) - $signed(PW'(pad));
          c0_nxt    = $signed(PW'(col_prod)) - $signed(PW'(pad));
          best_nxt  = mpool_pkg::SAMPLE_MIN;
          found_nxt = 1'b0;
          state_nxt = (win_size_r == 3'd0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_j) begin
          j_nxt = '0;
          if (last_i) begin
            state_nxt = ST_LAST;
          end else begin
            i_nxt = WIN_W'(i_r + 1'b1);
          end
        end else begin
          j_nxt = WIN_W'(j_r + 1'b1);
        end
      end
      ST_LAST: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = best_r;
          out_empty_nxt = !found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    r0_r        <= r0_nxt;
    c0_r        <= c0_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    out_max_r   <= out_max_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.max_value    = out_max_r;
  assign out_chan.window_empty = out_empty_r;

`ifndef SYNTH
  // a read result is only pending right after a walk cycle
  a_pend_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == ST_RUN))
    else $error("read pending outside window walk");

  // a query blocks further items on the next cycle
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_query) |=> !in_chan.ready)
    else $error("query did not start a window walk");

  // a write never produces a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_query && !out_valid_r) |=> !out_valid_r)
    else $error("write produced a result");

  // a held result is not overwritten by the finishing query
  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_chan.ready) |=>
      (state_r == ST_FINISH && $stable(out_max_r)))
    else $error("result register overwritten");

  // an empty window always reports the most negative value
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_max_r == mpool_pkg::SAMPLE_MIN))
    else $error("empty window with non-minimum value");
`endif

endmodule

@@ rtl/mpool_ram.sv @@
// ----------------------------------------------------------------------------
// mpool_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpool_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_pool_2d_window_top. Samples are written into the
// plane and square windows are queried under many window, step and plane-size
// settings. A scoreboard keeps its own copy of the plane and the settings and
// computes the pooled maximum and empty flag of every query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mpool_pkg::*;

  localparam int PLANE_ROWS     = 64;
  localparam int PLANE_COLS     = 64;
  localparam int WIN_MAX        = 7;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 66;
  localparam int NUM_PHASES     = 12;

  typedef struct {
    logic signed [SAMPLE_W-1:0] max_value;
    logic                       window_empty;
  } pooled_t;

  class pool_scoreboard;
    logic signed [SAMPLE_W-1:0] plane [PLANE_ROWS*PLANE_COLS];
    bit                         written [PLANE_ROWS*PLANE_COLS];
    int                         win_size;
    int                         step;
    int                         height;
    int                         width;
    pooled_t                    expected_maxima [$];
    int                         errors;
    int                         checked;
    int                         empties;

    function new();
      win_size = WINDOW_SIZE_RST;
      step     = STEP_SIZE_RST;
      height   = PLANE_HEIGHT_RST;
      width    = PLANE_WIDTH_RST;
      errors   = 0;
      checked  = 0;
      empties  = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WINDOW_SIZE:  win_size = data[2:0];
        CFG_STEP_SIZE:    step     = data[2:0];
        CFG_PLANE_HEIGHT: height   = data;
        CFG_PLANE_WIDTH:  width    = data;
        default: ;
      endcase
    endfunction

    // in-plane part of the window; empty when lo > hi on either axis
    function void window_box(input int r, input int c,
                             output int r_lo, output int r_hi,
                             output int c_lo, output int c_hi);
      int rows, cols, k, pad, r0, c0;
      rows = (height > PLANE_ROWS) ? PLANE_ROWS : height;
      cols = (width > PLANE_COLS) ? PLANE_COLS : width;
      k    = (win_size > WIN_MAX) ? WIN_MAX : win_size;
      pad  = win_size / 2;
      r0   = r * step - pad;
      c0   = c * step - pad;
      r_lo = (r0 < 0) ? 0 : r0;
      c_lo = (c0 < 0) ? 0 : c0;
      r_hi = (r0 + k - 1 >= rows) ? rows - 1 : r0 + k - 1;
      c_hi = (c0 + k - 1 >= cols) ? cols - 1 : c0 + k - 1;
    endfunction

    function void take_request(req_t kind, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                               logic signed [SAMPLE_W-1:0] s);
      int      addr, r_lo, r_hi, c_lo, c_hi;
      pooled_t res;
      if (kind == REQ_WRITE) begin
        addr          = r * PLANE_COLS + c;
        plane[addr]   = s;
        written[addr] = 1'b1;
      end else begin
        window_box(r, c, r_lo, r_hi, c_lo, c_hi);
        res.max_value    = SAMPLE_MIN;
        res.window_empty = 1'b1;
        for (int i = r_lo; i <= r_hi; i++) begin
          for (int j = c_lo; j <= c_hi; j++) begin
            if (res.window_empty || plane[i*PLANE_COLS + j] > res.max_value)
              res.max_value = plane[i*PLANE_COLS + j];
            res.window_empty = 1'b0;
          end
        end
        expected_maxima.push_back(res);
      end
    endfunction

    function void check_pooled(logic signed [SAMPLE_W-1:0] mv, logic empty);
      pooled_t want;
      if (expected_maxima.size() == 0) begin
        errors++;
        $display("%0t: result with no query waiting: max_value %0d window_empty %0b",
                 $time, mv, empty);
        return;
      end
      want = expected_maxima.pop_front();
      checked++;
      if (want.window_empty)
        empties++;
      if (mv !== want.max_value) begin
        errors++;
        $display("%0t: max_value mismatch: expected %0d, actual %0d",
                 $time, want.max_value, mv);
      end
      if (empty !== want.window_empty) begin
        errors++;
        $display("%0t: window_empty mismatch: expected %0b, actual %0b",
                 $time, want.window_empty, empty);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  int                  in_idle_pct;
  int                  out_idle_pct;
  int                  n_writes;
  int                  n_queries;
  int                  quiet_cycles;
  pool_scoreboard      sb;

  mpool_in_if  in_if ();
  mpool_out_if out_if ();

  max_pool_2d_window_top #(
    .MAX_ROWS   (PLANE_ROWS),
    .MAX_COLS   (PLANE_COLS),
    .MAX_WINDOW (WIN_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check, then pick the ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready)
      sb.check_pooled(out_if.max_value, out_if.window_empty);
    out_if.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       return SAMPLE_MIN;
        1:       return 16'sh7fff;
        2:       return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  // output coordinate whose window mostly lands inside the plane
  function automatic int query_coord(input int extent, input int cap);
    int reach, lim;
    if ($urandom_range(99) < 20 || sb.step == 0)
      return $urandom_range(63);
    reach = ((extent > cap) ? cap : extent) - 1 + sb.win_size / 2;
    lim   = reach / sb.step;
    return $urandom_range((lim > 63) ? 63 : ((lim < 0) ? 0 : lim));
  endfunction

  task automatic send_item(input req_t kind, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= kind;
    in_if.row      <= r;
    in_if.col      <= c;
    in_if.sample   <= s;
    @(posedge clk);
    while (in_if.ready !== 1'b1)
      @(posedge clk);
    sb.take_request(kind, r, c, s);
    if (kind == REQ_WRITE)
      n_writes++;
    else
      n_queries++;
  endtask

  // store every in-plane window sample not yet written, then query
  task automatic issue_query(input int r, input int c);
    int r_lo, r_hi, c_lo, c_hi;
    sb.window_box(r, c, r_lo, r_hi, c_lo, c_hi);
    for (int i = r_lo; i <= r_hi; i++) begin
      for (int j = c_lo; j <= c_hi; j++) begin
        if (!sb.written[i*PLANE_COLS + j])
          send_item(REQ_WRITE, ROW_W'(i), COL_W'(j), random_sample());
      end
    end
    send_item(REQ_QUERY, ROW_W'(r), COL_W'(c), random_sample());
  endtask

  task automatic program_pooling(input int win, input int step, input int height,
                                 input int width);
    cfg_idx_t         reg_idx [4];
    logic [CFG_W-1:0] reg_val [4];
    logic [3:0]       noise;
    reg_idx = '{CFG_WINDOW_SIZE, CFG_STEP_SIZE, CFG_PLANE_HEIGHT, CFG_PLANE_WIDTH};
    // spare upper bits of the 3-bit registers carry noise
    noise      = 4'($urandom);
    reg_val[0] = {noise, win[2:0]};
    noise      = 4'($urandom);
    reg_val[1] = {noise, step[2:0]};
    reg_val[2] = height[6:0];
    reg_val[3] = width[6:0];
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= reg_val[i];
      @(posedge clk);
      sb.set_reg(reg_idx[i], reg_val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // wait for every pending result, then let a write in flight settle
  task automatic drain();
    while (sb.expected_maxima.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // window fills count toward the phase budget
  task automatic run_phase(input int win, input int step, input int height,
                           input int width);
    int phase_end;
    program_pooling(win, step, height, width);
    phase_end = n_writes + n_queries + PHASE_ITEMS;
    while (n_writes + n_queries < phase_end) begin
      if ($urandom_range(99) < 40)
        send_item(REQ_WRITE, ROW_W'($urandom), COL_W'($urandom), random_sample());
      else
        issue_query(query_coord(sb.height, PLANE_ROWS), query_coord(sb.width, PLANE_COLS));
    end
    in_if.valid <= 1'b0;
    drain();
  endtask

  initial begin : main
    int setups [NUM_PHASES][4];
    setups = '{'{5, 1, 64, 64}, '{7, 7, 64, 64}, '{0, 3, 64, 64}, '{3, 0, 20, 20},
               '{1, 1, 1, 1},   '{7, 2, 0, 17},  '{4, 3, 127, 100}, '{6, 5, 13, 64},
               '{7, 1, 64, 0},  '{1, 7, 64, 64}, '{2, 2, 33, 9},  '{3, 1, 64, 64}};
    sb             = new();
    n_writes       = 0;
    n_queries      = 0;
    in_idle_pct    = 6;
    out_idle_pct   = 66;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_WINDOW_SIZE;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.req_type <= REQ_WRITE;
    in_if.row      <= '0;
    in_if.col      <= '0;
    in_if.sample   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 5x5 window at the corner, first with all samples at the minimum, then with one at the maximum
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++)
        send_item(REQ_WRITE, ROW_W'(i), COL_W'(j), SAMPLE_MIN);
    end
    issue_query(0, 0);
    send_item(REQ_WRITE, 6'd1, 6'd1, 16'sh7fff);
    issue_query(0, 0);
    in_if.valid <= 1'b0;
    drain();

    // 2x2 window on the far corner of the store
    program_pooling(2, 1, 64, 64);
    send_item(REQ_WRITE, 6'd62, 6'd62, 16'sh0001);
    send_item(REQ_WRITE, 6'd62, 6'd63, -16'sd1);
    send_item(REQ_WRITE, 6'd63, 6'd62, 16'sh7fff);
    send_item(REQ_WRITE, 6'd63, 6'd63, SAMPLE_MIN);
    issue_query(63, 63);
    in_if.valid <= 1'b0;
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        in_idle_pct  = 6;
        out_idle_pct = 66;
      end else if (p < 8) begin
        in_idle_pct  = 66;
        out_idle_pct = 6;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (p >= NUM_PHASES - 2)
        run_phase($urandom_range(7), $urandom_range(7), $urandom_range(1, 64),
                  $urandom_range(1, 64));
      else
        run_phase(setups[p][0], setups[p][1], setups[p][2], setups[p][3]);
    end

    $display("ran %0d sample writes and %0d window queries over %0d pooling setups",
             n_writes, n_queries, NUM_PHASES + 2);
    $display("checked %0d pooled results, %0d of them from empty windows",
             sb.checked, sb.empties);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ max_pool_2d_window_top.f @@
rtl/mpool_pkg.sv
rtl/mpool_if.sv
rtl/mpool_ram.sv
rtl/max_pool_2d_window_top.sv
sim/tb.sv
